>>> hdl/a2pa_pkg.sv
// shared constants, series coefficients and stage record for the atan2 pipeline
// no dependencies
`default_nettype none
package a2pa_pkg;
   localparam int QB = 30;
   localparam int QW = 32;
   localparam int NTERMS_LO = 15;
   localparam int NTERMS_HI = 12;
   localparam logic [QW-1:0] Q_PI   = 32'd3373259426;
   localparam logic [QW-1:0] Q_PI_2 = 32'd1686629713;
   localparam logic [QW-1:0] Q_PI_4 = 32'd843314857;

   function automatic logic [QW-1:0] inv_odd(input logic [3:0] k);
      logic [QW-1:0] v;
      case (k)
         4'd0: v = 32'd1073741824;
         4'd1: v = 32'd357913941;
         4'd2: v = 32'd214748365;
         4'd3: v = 32'd153391689;
         4'd4: v = 32'd119304647;
         4'd5: v = 32'd97612893;
         4'd6: v = 32'd82595525;
         4'd7: v = 32'd71582788;
         4'd8: v = 32'd63161284;
         4'd9: v = 32'd56512728;
         4'd10: v = 32'd51130563;
         4'd11: v = 32'd46684427;
         4'd12: v = 32'd42949673;
         4'd13: v = 32'd39768216;
         4'd14: v = 32'd37025580;
         default: v = '0;
      endcase
      return v;
   endfunction

   // octant control carried alongside the data
   typedef struct packed {
      logic valid;
      logic hi;
      logic xzero;
      logic yzero;
      logic steep;
      logic neg;
      logic xneg;
      logic yneg;
   } ctl_type;
endpackage
`default_nettype wire

>>> hdl/atan2_polynomial_approx.sv
// Four-quadrant arctangent pipeline. Accepts one coordinate pair per cycle unless
// stalled and passes each pair through one setup stage, 31 divider
// cells (one quotient bit each), a square stage, 14 horner cells, a final
// multiply stage and an octant/rounding stage. The output register decouples
// the result side; a stall freezes the whole chain. Depends on a2pa_pkg.
`default_nettype none
module atan2_polynomial_approx #(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [COORD_WIDTH-1:0]  req_coord_y,
   input  wire logic signed [COORD_WIDTH-1:0]  req_coord_x,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [ANGLE_FRAC_BITS+2:0]   rsp_angle
);
   localparam int QB = a2pa_pkg::QB;
   localparam int MW = COORD_WIDTH + 1;
   localparam int ND = QB + 1;
   localparam int NH = a2pa_pkg::NTERMS_LO - 1;
   localparam int SH = QB - ANGLE_FRAC_BITS;
   localparam int OW = ANGLE_FRAC_BITS + 3;

   logic en;
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // setup
   a2pa_pkg::ctl_type c0_in;
   logic [COORD_WIDTH:0] ay, ax, a, b;
   logic [MW:0] num0, den0;
   always_comb begin
      ay = req_coord_y[COORD_WIDTH-1] ? (COORD_WIDTH+1)'(-{req_coord_y[COORD_WIDTH-1], req_coord_y})
                                      : {1'b0, req_coord_y};
      ax = req_coord_x[COORD_WIDTH-1] ? (COORD_WIDTH+1)'(-{req_coord_x[COORD_WIDTH-1], req_coord_x})
                                      : {1'b0, req_coord_x};
      c0_in.valid = req_valid;
      c0_in.steep = ay > ax;
      a = c0_in.steep ? ax : ay;
      b = c0_in.steep ? ay : ax;
      c0_in.hi = ({a, 1'b0} >= {1'b0, b});
      c0_in.xzero = ax == '0;
      c0_in.yzero = ay == '0;
      c0_in.xneg = req_coord_x[COORD_WIDTH-1];
      c0_in.yneg = req_coord_y[COORD_WIDTH-1];
      c0_in.neg = c0_in.xneg != c0_in.yneg;
      num0 = c0_in.hi ? {1'b0, b - a} : {1'b0, a};
      den0 = c0_in.hi ? (MW+1)'(a + b) : {1'b0, b};
      if (c0_in.xzero) den0 = (MW+1)'(1);
   end

   a2pa_pkg::ctl_type dctl [ND+1];
   logic [MW:0] drem [ND+1];
   logic [MW:0] dden [ND+1];
   logic [QB:0] dquo [ND+1];

   // numerator < den so the remainder starts as the numerator
   a2pa_pkg::ctl_type s0ctl_ff;
   logic [MW:0] s0num_ff, s0den_ff;
   always_ff @(posedge clock) begin
      if (reset) s0ctl_ff <= '0;
      else if (en) s0ctl_ff <= c0_in;
      if (en) begin
         s0num_ff <= num0;
         s0den_ff <= den0;
      end
   end
   assign dctl[0] = s0ctl_ff;
   assign drem[0] = s0num_ff;
   assign dden[0] = s0den_ff;
   assign dquo[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < ND; gi++) begin : g_div
         a2pa_div_cell #(.MW(MW)) u_cell (
            .clock(clock), .reset(reset), .en(en),
            .ctl_in(dctl[gi]), .rem_in(drem[gi]),
            .den_in(dden[gi]), .quo_in(dquo[gi]),
            .ctl_out(dctl[gi+1]), .rem_out(drem[gi+1]),
            .den_out(dden[gi+1]), .quo_out(dquo[gi+1])
         );
      end
   endgenerate

   // quotient: 31 bits = num*2^31/den; dropping the last bit gives Q30
   logic [QB:0] v;
   assign v = {1'b0, dquo[ND][QB:1]};

   // square stage
   a2pa_pkg::ctl_type sctl_ff;
   logic [QB:0] sv_ff, sv2_ff;
   logic [2*QB+1:0] sq;
   assign sq = v * v;
   always_ff @(posedge clock) begin
      if (reset) sctl_ff <= '0;
      else if (en) sctl_ff <= dctl[ND];
      if (en) begin
         sv_ff <= v;
         sv2_ff <= sq[2*QB:QB];
      end
   end

   a2pa_pkg::ctl_type hctl [NH+1];
   logic [QB:0] hv [NH+1];
   logic [QB:0] hv2 [NH+1];
   logic [QB:0] hacc [NH+1];
   assign hctl[0] = sctl_ff;
   assign hv[0] = sv_ff;
   assign hv2[0] = sv2_ff;
   assign hacc[0] = (QB+1)'(a2pa_pkg::inv_odd(4'(a2pa_pkg::NTERMS_LO - 1)));

   generate
      for (gi = 0; gi < NH; gi++) begin : g_hor
         a2pa_horner_cell #(.K(NH - 1 - gi)) u_cell (
            .clock(clock), .reset(reset), .en(en),
            .ctl_in(hctl[gi]), .v_in(hv[gi]), .v2_in(hv2[gi]), .acc_in(hacc[gi]),
            .ctl_out(hctl[gi+1]), .v_out(hv[gi+1]), .v2_out(hv2[gi+1]),
            .acc_out(hacc[gi+1])
         );
      end
   endgenerate

   // final multiply
   a2pa_pkg::ctl_type mctl_ff;
   logic [QB:0] f_ff;
   logic [2*QB+1:0] fp;
   assign fp = hv[NH] * hacc[NH];
   always_ff @(posedge clock) begin
      if (reset) mctl_ff <= '0;
      else if (en) mctl_ff <= hctl[NH];
      if (en) f_ff <= fp[2*QB:QB];
   end

   // octant and rounding
   logic signed [QB+3:0] fm, f, ang, mag;
   logic [QB+3:0] rmag;
   logic signed [OW-1:0] r;
   always_comb begin
      fm = mctl_ff.hi ? (QB+4)'($signed({1'b0, a2pa_pkg::Q_PI_4}) - $signed({1'b0, f_ff}))
                      : $signed({3'b0, f_ff});
      f = mctl_ff.neg ? -fm : fm;
      if (mctl_ff.xzero)
         ang = mctl_ff.yzero ? '0 : (mctl_ff.yneg ? -$signed({2'b0, a2pa_pkg::Q_PI_2})
                                                  : $signed({2'b0, a2pa_pkg::Q_PI_2}));
      else if (mctl_ff.steep)
         ang = (mctl_ff.yneg ? -$signed({2'b0, a2pa_pkg::Q_PI_2})
                             : $signed({2'b0, a2pa_pkg::Q_PI_2})) - f;
      else if (!mctl_ff.xneg)
         ang = f;
      else
         ang = (mctl_ff.yneg ? -$signed({2'b0, a2pa_pkg::Q_PI})
                             : $signed({2'b0, a2pa_pkg::Q_PI})) + f;
      mag = ang[QB+3] ? -ang : ang;
      rmag = ($unsigned(mag) + (QB+4)'(1) * (QB+4)'(2 ** (SH - 1))) >> SH;
      r = ang[QB+3] ? OW'(-rmag) : OW'(rmag);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (en) rsp_valid <= mctl_ff.valid;
      if (en) rsp_angle <= r;
   end
endmodule
`default_nettype wire

>>> hdl/a2pa_div_cell.sv
// one restoring divide step cell, produces one quotient bit per cycle while en is high
// depends on a2pa_pkg
`default_nettype none
module a2pa_div_cell #(
   parameter int MW = 17
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire a2pa_pkg::ctl_type      ctl_in,
   input  wire logic [MW:0]            rem_in,
   input  wire logic [MW:0]            den_in,
   input  wire logic [a2pa_pkg::QB:0]  quo_in,
   output a2pa_pkg::ctl_type           ctl_out,
   output logic [MW:0]                 rem_out,
   output logic [MW:0]                 den_out,
   output logic [a2pa_pkg::QB:0]       quo_out
);
   a2pa_pkg::ctl_type ctl_ff;
   logic [MW:0] rem_ff, den_ff, rem_in2;
   logic [MW+1:0] sh;
   logic [a2pa_pkg::QB:0] quo_ff;
   logic bit_q;

   always_comb begin
      sh = {rem_in, 1'b0};
      bit_q = sh >= {1'b0, den_in};
      rem_in2 = bit_q ? (MW+1)'(sh - {1'b0, den_in}) : sh[MW:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
      if (en) begin
         rem_ff <= rem_in2;
         den_ff <= den_in;
         quo_ff <= {quo_in[a2pa_pkg::QB-1:0], bit_q};
      end
   end
   assign ctl_out = ctl_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;
endmodule
`default_nettype wire

>>> hdl/a2pa_horner_cell.sv
// one horner step cell of the odd series: acc = c - acc * v2 (sign folded)
// depends on a2pa_pkg
`default_nettype none
module a2pa_horner_cell #(
   parameter int K = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire a2pa_pkg::ctl_type       ctl_in,
   input  wire logic [a2pa_pkg::QB:0]   v_in,
   input  wire logic [a2pa_pkg::QB:0]   v2_in,
   input  wire logic [a2pa_pkg::QB:0]   acc_in,
   output a2pa_pkg::ctl_type            ctl_out,
   output logic [a2pa_pkg::QB:0]        v_out,
   output logic [a2pa_pkg::QB:0]        v2_out,
   output logic [a2pa_pkg::QB:0]        acc_out
);
   // acc held as magnitude; terms alternate sign and magnitudes stay positive
   a2pa_pkg::ctl_type ctl_ff;
   logic [a2pa_pkg::QB:0] v_ff, v2_ff, acc_ff, acc_in2, prod;
   logic [2*a2pa_pkg::QB+1:0] full;
   logic [3:0] kk;
   logic act;

   always_comb begin
      act = ctl_in.hi ? (K < a2pa_pkg::NTERMS_HI - 1) : 1'b1;
      kk = 4'(K);
      full = acc_in * v2_in;
      prod = full[2*a2pa_pkg::QB:a2pa_pkg::QB];
      if (ctl_in.hi && K == a2pa_pkg::NTERMS_HI - 1)
         acc_in2 = (a2pa_pkg::QB+1)'(a2pa_pkg::inv_odd(4'(a2pa_pkg::NTERMS_HI - 1)));
      else if (act)
         acc_in2 = (a2pa_pkg::QB+1)'(a2pa_pkg::inv_odd(kk)) - prod;
      else
         acc_in2 = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) ctl_ff <= '0;
      else if (en) ctl_ff <= ctl_in;
      if (en) begin
         v_ff <= v_in;
         v2_ff <= v2_in;
         acc_ff <= acc_in2;
      end
   end
   assign ctl_out = ctl_ff;
   assign v_out = v_ff;
   assign v2_out = v2_ff;
   assign acc_out = acc_ff;
endmodule
`default_nettype wire

>>> bench/atan2_polynomial_approx_tb.sv
// self-checking testbench for the atan2_polynomial_approx pipeline
// predicts each angle that is not typed with a local fixed-point model; depends on the rtl only
`timescale 1ns / 100ps
`default_nettype none
module atan2_polynomial_approx_tb;
   localparam int CW = 16;
   localparam int AFB = 13;
   localparam int AW = AFB + 3;
   localparam longint QPI = 64'd3373259426;
   localparam longint QPI2 = 64'd1686629713;
   localparam longint QPI4 = 64'd843314857;
   localparam int NUM_RANDOM = 1800;
   localparam int NUM_DIRECTED = 22;
   localparam logic signed [AW-1:0] NO_CHECK = -16'sd32768;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CW-1:0] req_coord_y = '0;
   logic signed [CW-1:0] req_coord_x = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [AW-1:0] rsp_angle;

   logic signed [AW-1:0] angle_queue[$];
   int errors = 0;
   int angles_seen = 0;
   bit sending_done = 1'b0;
   bit hold_done = 1'b0;

   atan2_polynomial_approx #(.COORD_WIDTH(CW), .ANGLE_FRAC_BITS(AFB)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_y(req_coord_y), .req_coord_x(req_coord_x),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_angle(rsp_angle)
   );

   always #5 clock = ~clock;

   longint inv_odd[15] = '{
      1073741824, 357913941, 214748365, 153391689, 119304647,
      97612893, 82595525, 71582788, 63161284, 56512728,
      51130563, 46684427, 42949673, 39768216, 37025580
   };

   function automatic longint qmul(longint a, longint b);
      longint ma, mb, p;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = (ma * mb) >>> 30;
      return ((a < 0) != (b < 0)) ? -p : p;
   endfunction

   function automatic longint odd_series(longint v, int nterms);
      longint v2, acc, c;
      int k;
      v2 = qmul(v, v);
      k = nterms - 1;
      acc = k[0] ? -inv_odd[k] : inv_odd[k];
      for (k = nterms - 2; k >= 0; k--) begin
         c = k[0] ? -inv_odd[k] : inv_odd[k];
         acc = c + qmul(acc, v2);
      end
      return qmul(v, acc);
   endfunction

   function automatic longint atan_ratio(longint a, longint b);
      if (2 * a >= b)
         return QPI4 + odd_series(-(((b - a) <<< 30) / (a + b)), 12);
      return odd_series((a <<< 30) / b, 15);
   endfunction

   function automatic logic signed [AW-1:0] predict_angle(logic signed [CW-1:0] cy,
                                                          logic signed [CW-1:0] cx);
      longint y, x, ay, ax, f, ang, r;
      bit steep;
      y = cy;
      x = cx;
      ay = (y < 0) ? -y : y;
      ax = (x < 0) ? -x : x;
      if (x == 0) begin
         ang = (y > 0) ? QPI2 : ((y < 0) ? -QPI2 : 0);
      end else begin
         steep = ay > ax;
         f = steep ? atan_ratio(ax, ay) : atan_ratio(ay, ax);
         if ((x < 0) != (y < 0)) f = -f;
         if (steep) ang = ((y >= 0) ? QPI2 : -QPI2) - f;
         else if (x > 0) ang = f;
         else ang = ((y >= 0) ? QPI : -QPI) + f;
      end
      if (ang >= 0) r = (ang + (64'sd1 <<< 16)) >>> 17;
      else r = -((-ang + (64'sd1 <<< 16)) >>> 17);
      return r[AW-1:0];
   endfunction

   // directed rows: y, x, typed angle or NO_CHECK to use the predictor
   typedef struct {
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] x;
      logic signed [AW-1:0] angle;
   } row_type;

   row_type directed[NUM_DIRECTED] = '{
      '{16'sd0, 16'sd0, 16'sd0},
      '{16'sd1, 16'sd0, 16'sd12868},
      '{-16'sd1, 16'sd0, -16'sd12868},
      '{16'sd0, 16'sd5, 16'sd0},
      '{16'sd0, -16'sd5, 16'sd25736},
      '{16'sd32767, 16'sd0, 16'sd12868},
      '{-16'sd32768, 16'sd0, -16'sd12868},
      '{16'sd0, -16'sd32768, 16'sd25736},
      '{16'sd0, 16'sd32767, 16'sd0},
      '{-16'sd32768, -16'sd32768, NO_CHECK},
      '{16'sd32767, 16'sd32767, NO_CHECK},
      '{-16'sd32768, 16'sd32767, NO_CHECK},
      '{16'sd32767, -16'sd32768, NO_CHECK},
      '{16'sd100, 16'sd200, NO_CHECK},
      '{16'sd99, 16'sd200, NO_CHECK},
      '{-16'sd100, 16'sd200, NO_CHECK},
      '{16'sd200, 16'sd100, NO_CHECK},
      '{-16'sd200, -16'sd100, NO_CHECK},
      '{16'sd1, -16'sd32768, NO_CHECK},
      '{-16'sd1, -16'sd32768, NO_CHECK},
      '{16'sd7, -16'sd7, NO_CHECK},
      '{-16'sd3, 16'sd1, NO_CHECK}
   };

   task automatic send_request(logic signed [CW-1:0] y, logic signed [CW-1:0] x,
                               logic signed [AW-1:0] angle);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_y <= y;
      req_coord_x <= x;
      angle_queue.push_back((angle == NO_CHECK) ? predict_angle(y, x) : angle);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1: return $signed(16'($urandom_range(0, 8))) - 16'sd4;
         default: return $signed(16'($urandom()));
      endcase
   endfunction

   initial begin
      logic signed [CW-1:0] y, x;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_request(directed[i].y, directed[i].x, directed[i].angle);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         y = pick_coord();
         x = pick_coord();
         // steer toward diagonals and the half-ratio boundary
         case ($urandom_range(0, 7))
            0: x = ($urandom_range(0, 1)) ? y : -y;
            1: x = (y >>> 1) + $signed(16'($urandom_range(0, 2))) - 16'sd1;
            default: ;
         endcase
         send_request(y, x, NO_CHECK);
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      int gap;
      @(negedge reset);
      repeat (60) @(posedge clock);
      rsp_stall <= 1'b1;
      repeat (120) @(posedge clock);
      rsp_stall <= 1'b0;
      hold_done = 1'b1;
      forever begin
         gap = $urandom_range(0, 3);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      logic signed [AW-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         angles_seen++;
         if (angle_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected angle %0d", $time, rsp_angle);
         end else begin
            want = angle_queue.pop_front();
            if (rsp_angle !== want) begin
               errors++;
               $display("%0t: angle expected %0d actual %0d", $time, want, rsp_angle);
            end
         end
      end
   end

   initial begin
      wait (sending_done && hold_done);
      while (angle_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d directed and %0d random coordinate pairs, %0d angles checked",
               NUM_DIRECTED, NUM_RANDOM, angles_seen);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #500000;
      $display("timeout with %0d requests outstanding", angle_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
